// ----- rtl/signed_int_to_decimal_ascii_defines.svh -----
// assertion macros used by the checker file of the decimal text converter
// no dependencies; included by bare file name
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SDTA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled during reset
`define SDTA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/sdta_pkg.sv -----
// types and constants for the signed integer to decimal text converter
// no dependencies; used by every module of the block
`default_nettype none

package sdta_pkg;

    localparam int DIG_W = 4;

    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    localparam logic [DIG_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [DIG_W-1:0] BCD_ADJ     = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_DIGIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } t_dab_cmd;

endpackage

`default_nettype wire

// ----- rtl/sdta_dabble.sv -----
// shared shift-and-add-3 unit: magnitude register and packed bcd digit register
// depends on sdta_pkg (command struct, digit constants)
`default_nettype none

module sdta_dabble #(
    parameter int VALUE_BITS = 32,
    parameter int NDIG       = 10
) (
    input  wire logic                         i_clk,
    input  wire sdta_pkg::t_dab_cmd           i_cmd,
    input  wire logic [VALUE_BITS-1:0]        i_value,
    output logic      [sdta_pkg::DIG_W-1:0]   o_top_digit
);

    localparam int BCD_W = NDIG * sdta_pkg::DIG_W;

    logic [VALUE_BITS-1:0] r_mag;
    logic [VALUE_BITS-1:0] n_mag;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      n_bcd;
    logic [BCD_W-1:0]      w_adj;

    always_comb begin
        w_adj = r_bcd;
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[i*sdta_pkg::DIG_W +: sdta_pkg::DIG_W] >= sdta_pkg::BCD_ADJ_MIN) begin
                w_adj[i*sdta_pkg::DIG_W +: sdta_pkg::DIG_W] =
                    r_bcd[i*sdta_pkg::DIG_W +: sdta_pkg::DIG_W] + sdta_pkg::BCD_ADJ;
            end
        end
    end

    always_comb begin
        n_mag = r_mag;
        n_bcd = r_bcd;
        if (i_cmd.load) begin
            // two's complement magnitude; the most negative value maps to 2^(n-1)
            n_mag = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
            n_bcd = '0;
        end else if (i_cmd.step) begin
            n_bcd = {w_adj[BCD_W-2:0], r_mag[VALUE_BITS-1]};
            n_mag = {r_mag[VALUE_BITS-2:0], 1'b0};
        end else if (i_cmd.shift) begin
            n_bcd = {r_bcd[BCD_W-sdta_pkg::DIG_W-1:0], {sdta_pkg::DIG_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= n_mag;
        r_bcd <= n_bcd;
    end

    assign o_top_digit = r_bcd[BCD_W-1 -: sdta_pkg::DIG_W];

endmodule

`default_nettype wire

// ----- rtl/signed_int_to_decimal_ascii.sv -----
// signed integer to decimal ascii text converter, top level
// depends on sdta_pkg and sdta_dabble
//
// usage:
//  - slave stream: one signed VALUE_BITS integer per transfer on i_s_axis_tdata
//    (low VALUE_BITS bits, rest is zero padding and ignored)
//  - master stream: one ascii character per transfer on o_m_axis_tdata, '-' first
//    for a negative value, then the digits most significant first without leading
//    zeros; o_m_axis_tlast marks the final digit of each number
//  - o_s_axis_tready is high only while the converter is idle; one number is
//    worked on at a time
//  - per number: shift-and-add-3 (one input bit per cycle through the shared bcd
//    unit), then the leading zero digits are skipped and a decision is taken,
//    then the characters go out one by one, waiting while the receiver stalls,
//    then the converter returns to idle
//  - a registered output stage holds each character until taken; while the
//    receiver stalls the sequencer waits and nothing is lost
//  - i_rst_n (synchronous, active low) returns to idle and drops o_m_axis_tvalid
`default_nettype none

module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // value
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // character
    output logic [7:0]                               o_m_axis_tdata,
    output logic                                     o_m_axis_tlast
);

    localparam int NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int CNT_W = $clog2(VALUE_BITS);

    sdta_pkg::t_state   r_state;
    sdta_pkg::t_state   n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;
    logic               r_neg;
    logic               n_neg;

    logic               r_out_valid;
    logic [7:0]         r_out_char;
    logic               r_out_last;

    sdta_pkg::t_dab_cmd w_cmd;
    logic [sdta_pkg::DIG_W-1:0] w_top;
    logic               w_in_xfer;
    logic               w_can_load;
    logic               w_out_load;
    logic [7:0]         w_out_char;
    logic               w_out_last;

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_can_load = !r_out_valid || i_m_axis_tready;

    sdta_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NDIG       (NDIG)
    ) u_dabble (
        .i_clk       (i_clk),
        .i_cmd       (w_cmd),
        .i_value     (i_s_axis_tdata[VALUE_BITS-1:0]),
        .o_top_digit (w_top)
    );

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        case (r_state)
            sdta_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = sdta_pkg::ST_CONV;
                    n_cnt   = CNT_W'(VALUE_BITS - 1);
                    n_neg   = i_s_axis_tdata[VALUE_BITS-1];
                end
            end
            sdta_pkg::ST_CONV: begin
                if (r_cnt == '0) begin
                    n_state = sdta_pkg::ST_SKIP;
                    n_cnt   = CNT_W'(NDIG - 1);
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            sdta_pkg::ST_SKIP: begin
                if (w_top == '0 && r_cnt != '0) begin
                    n_cnt = r_cnt - 1'b1;
                end else if (r_neg) begin
                    n_state = sdta_pkg::ST_SIGN;
                end else begin
                    n_state = sdta_pkg::ST_DIGIT;
                end
            end
            sdta_pkg::ST_SIGN: begin
                if (w_can_load) begin
                    n_state = sdta_pkg::ST_DIGIT;
                end
            end
            sdta_pkg::ST_DIGIT: begin
                if (w_can_load) begin
                    if (r_cnt == '0) begin
                        n_state = sdta_pkg::ST_IDLE;
                    end else begin
                        n_cnt = r_cnt - 1'b1;
                    end
                end
            end
            default: begin
                n_state = sdta_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_cmd           = '0;
        w_out_load      = 1'b0;
        w_out_char      = sdta_pkg::CHAR_ZERO + {4'b0, w_top};
        w_out_last      = (r_cnt == '0);
        case (r_state)
            sdta_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_cmd.load      = i_s_axis_tvalid;
            end
            sdta_pkg::ST_CONV: begin
                w_cmd.step = 1'b1;
            end
            sdta_pkg::ST_SKIP: begin
                w_cmd.shift = (w_top == '0 && r_cnt != '0);
            end
            sdta_pkg::ST_SIGN: begin
                w_out_load = w_can_load;
                w_out_char = sdta_pkg::CHAR_MINUS;
                w_out_last = 1'b0;
            end
            sdta_pkg::ST_DIGIT: begin
                w_out_load  = w_can_load;
                w_cmd.shift = w_can_load;
            end
            default: begin
                w_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdta_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        if (w_out_load) begin
            r_out_char <= w_out_char;
            r_out_last <= w_out_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/sdta_checker.sv -----
// port-level checks for the decimal text converter, bound to the top level
// depends on sdta_pkg and signed_int_to_decimal_ascii_defines.svh
`default_nettype none
`include "signed_int_to_decimal_ascii_defines.svh"

module sdta_checker (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_axis_tvalid,
    input  wire logic       o_s_axis_tready,
    input  wire logic       o_m_axis_tvalid,
    input  wire logic       i_m_axis_tready,
    input  wire logic [7:0] o_m_axis_tdata,
    input  wire logic       o_m_axis_tlast
);

    logic       w_is_minus;
    logic       w_is_digit;
    logic       w_in_xfer;
    logic       w_stall;
    logic       w_out_minus;
    logic [8:0] w_beat;

    assign w_is_minus  = (o_m_axis_tdata == sdta_pkg::CHAR_MINUS);
    assign w_is_digit  = (o_m_axis_tdata >= sdta_pkg::CHAR_ZERO)
                      && (o_m_axis_tdata <= sdta_pkg::CHAR_NINE);
    assign w_in_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_stall     = o_m_axis_tvalid && !i_m_axis_tready;
    assign w_out_minus = o_m_axis_tvalid && w_is_minus;
    assign w_beat      = {o_m_axis_tlast, o_m_axis_tdata};

    // a stalled character holds
    `SDTA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, o_m_axis_tvalid && $stable(w_beat))
    // busy right after taking a number
    `SDTA_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, w_in_xfer, !o_s_axis_tready)
    // only sign or digit characters leave
    `SDTA_ASSERT_NOW(a_char_set, i_clk, i_rst_n, o_m_axis_tvalid, w_is_minus || w_is_digit)
    // the sign is never the final character
    `SDTA_ASSERT_NOW(a_minus_not_last, i_clk, i_rst_n, w_out_minus, !o_m_axis_tlast)

endmodule

bind signed_int_to_decimal_ascii sdta_checker u_sdta_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire
